[design/tmcr_pkg.sv]
package tmcr_pkg;

    // text grid and glyph geometry
    localparam int TEXT_COLS   = 80;
    localparam int TEXT_ROWS   = 25;
    localparam int GLYPH_LINES = 16;

    localparam int LINE_W      = $clog2(GLYPH_LINES);
    localparam int NUM_CELLS   = TEXT_COLS * TEXT_ROWS;

    // reciprocal of the column count, 16 fraction bits
    localparam int COL_RECIP   = 65536 / TEXT_COLS;

    // video window, organized as 16-bit words (even byte low, odd byte high)
    localparam int WIN_WORDS   = 4096;
    localparam int WADDR_W     = $clog2(WIN_WORDS);

    localparam logic [12:0] PAL_BASE  = 13'h0FA0;
    localparam logic [12:0] PAL_END   = 13'h0FC0;
    localparam logic [12:0] FONT_BASE = 13'h1000;

    localparam logic [WADDR_W-1:0] PAL_WORD  = WADDR_W'(12'h7D0);
    localparam logic [WADDR_W-1:0] FONT_WORD = WADDR_W'(12'h800);

    // item function codes
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_RENDER = 1'b1;

    // result kinds
    localparam logic [1:0] REDRAW_PIXEL = 2'd0;
    localparam logic [1:0] REDRAW_CELL  = 2'd1;
    localparam logic [1:0] REDRAW_FULL  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_VIDEO_MODE = 2'd0;
    localparam logic [1:0] CFG_CURSOR_COL = 2'd1;
    localparam logic [1:0] CFG_CURSOR_ROW = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR_CELL,
        ST_RD_ATTR,
        ST_RD_PAL,
        ST_GLYPH
    } t_state;

    typedef struct packed {
        logic [7:0] video_mode;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
    } t_cfg;

    typedef struct packed {
        logic               we;
        logic [1:0]         be;
        logic [WADDR_W-1:0] waddr;
        logic [15:0]        wdata;
        logic [WADDR_W-1:0] raddr_a;
        logic [WADDR_W-1:0] raddr_b;
    } t_ram_req;

    typedef struct packed {
        logic [7:0][23:0] pixels;
        logic [9:0]       screen_x;
        logic [8:0]       screen_y;
        logic             last_row;
        logic [1:0]       redraw_kind;
    } t_result;

endpackage

[design/text_mode_cell_renderer_unit.sv]
// Text-mode cell renderer for an 80x25 display with an 8 KiB video window
// (cells, 16-color palette, 256-glyph 8x16 font). After reset the window is
// zeroed by a clearing pass, one 16-bit word a cycle; busy is high throughout
// and no item is taken. In video mode 0, a palette or font write shows its
// result in the cycle right after the item, while a write into the text region
// keeps busy high in ST_WR_CELL while the cell column and row are split, and
// its result is registered from that state. A render item for a cell inside
// the grid in video mode 0 keeps busy high for the cell word read, the palette
// read and then one font read per glyph line on the window memory's first read
// port, with the 16 glyph-line results on consecutive cycles. Each result is
// shown for a single cycle with o_result_strobe high and must be taken then.
// The configuration port is always ready and should be written only while the
// block is idle.
module text_mode_cell_renderer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_func,
    input  logic [12:0] i_window_offset,
    input  logic [7:0]  i_write_byte,
    input  logic [6:0]  i_cell_col,
    input  logic [4:0]  i_cell_row,
    input  logic        i_blink_phase,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_result_strobe,
    output logic [23:0] o_pixel_0,
    output logic [23:0] o_pixel_1,
    output logic [23:0] o_pixel_2,
    output logic [23:0] o_pixel_3,
    output logic [23:0] o_pixel_4,
    output logic [23:0] o_pixel_5,
    output logic [23:0] o_pixel_6,
    output logic [23:0] o_pixel_7,
    output logic [9:0]  o_screen_x,
    output logic [8:0]  o_screen_y,
    output logic        o_last_row,
    output logic [1:0]  o_redraw_kind
);
    import tmcr_pkg::*;

    t_cfg       r_cfg, n_cfg;
    t_ram_req   ram_req;
    logic [15:0] rdata_a;
    logic [15:0] rdata_b;
    t_result    res;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_VIDEO_MODE: n_cfg.video_mode = i_cfg_data;
                CFG_CURSOR_COL: n_cfg.cursor_col = i_cfg_data[6:0];
                CFG_CURSOR_ROW: n_cfg.cursor_row = i_cfg_data[4:0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // sequencer
    tmcr_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (start),
        .o_busy          (busy),
        .i_func          (i_func),
        .i_window_offset (i_window_offset),
        .i_write_byte    (i_write_byte),
        .i_cell_col      (i_cell_col),
        .i_cell_row      (i_cell_row),
        .i_blink_phase   (i_blink_phase),
        .i_cfg           (r_cfg),
        .o_ram_req       (ram_req),
        .i_rdata_a       (rdata_a),
        .i_rdata_b       (rdata_b),
        .o_valid         (o_result_strobe),
        .o_res           (res)
    );

    // video window
    tmcr_window_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // result ports
    assign o_pixel_0     = res.pixels[0];
    assign o_pixel_1     = res.pixels[1];
    assign o_pixel_2     = res.pixels[2];
    assign o_pixel_3     = res.pixels[3];
    assign o_pixel_4     = res.pixels[4];
    assign o_pixel_5     = res.pixels[5];
    assign o_pixel_6     = res.pixels[6];
    assign o_pixel_7     = res.pixels[7];
    assign o_screen_x    = res.screen_x;
    assign o_screen_y    = res.screen_y;
    assign o_last_row    = res.last_row;
    assign o_redraw_kind = res.redraw_kind;

endmodule

[design/tmcr_window_ram.sv]
module tmcr_window_ram (
    input  logic                          i_clk,
    input  tmcr_pkg::t_ram_req            i_req,
    output logic [15:0]                   o_rdata_a,
    output logic [15:0]                   o_rdata_b
);
    import tmcr_pkg::*;

    logic [1:0][7:0] mem [WIN_WORDS];

    // byte-enabled write port
    always_ff @(posedge i_clk) begin
        if (i_req.we && i_req.be[0]) begin
            mem[i_req.waddr][0] <= i_req.wdata[7:0];
        end
        if (i_req.we && i_req.be[1]) begin
            mem[i_req.waddr][1] <= i_req.wdata[15:8];
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        o_rdata_a <= mem[i_req.raddr_a];
        o_rdata_b <= mem[i_req.raddr_b];
    end

endmodule

[design/tmcr_seq.sv]
module tmcr_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic                  i_func,
    input  logic [12:0]           i_window_offset,
    input  logic [7:0]            i_write_byte,
    input  logic [6:0]            i_cell_col,
    input  logic [4:0]            i_cell_row,
    input  logic                  i_blink_phase,
    input  tmcr_pkg::t_cfg        i_cfg,
    output tmcr_pkg::t_ram_req    o_ram_req,
    input  logic [15:0]           i_rdata_a,
    input  logic [15:0]           i_rdata_b,
    output logic                  o_valid,
    output tmcr_pkg::t_result     o_res
);
    import tmcr_pkg::*;

    localparam logic [LINE_W-1:0] LAST_LINE   = LINE_W'(GLYPH_LINES - 1);
    localparam logic [LINE_W-1:0] CURSOR_LINE = LINE_W'(GLYPH_LINES - 2);

    t_state                 r_state, n_state;
    logic [WADDR_W-1:0]     r_clr_addr, n_clr_addr;
    logic                   r_valid, n_valid;
    t_result                r_res, n_res;

    logic [11:0]            r_cell, n_cell;
    logic [11:0]            r_q, n_q;
    logic [6:0]             r_col, n_col;
    logic [4:0]             r_row, n_row;
    logic                   r_cursor, n_cursor;
    logic [7:0]             r_ch, n_ch;
    logic [23:0]            r_fg, n_fg;
    logic [23:0]            r_bg, n_bg;
    logic [LINE_W-1:0]      r_line, n_line;

    // cell locate arithmetic
    logic [18:0]            col_prod;
    logic [11:0]            col_rem;
    logic                   col_over;
    logic [11:0]            col_fin;
    logic [8:0]             y_est;

    // glyph line shading
    logic [7:0]             font_byte;
    logic [LINE_W-1:0]      next_line;

    // palette word to 24-bit rgb
    function automatic logic [23:0] pal_rgb(input logic [15:0] w);
        pal_rgb = {w[11:8], 4'h0, w[7:4], 4'h0, w[3:0], 4'h0};
    endfunction

    // word address of one glyph line
    function automatic logic [WADDR_W-1:0] font_addr(input logic [7:0] ch,
                                                     input logic [LINE_W-1:0] line);
        font_addr = FONT_WORD | WADDR_W'({ch, 3'(line >> 1)});
    endfunction

    assign o_busy  = (r_state != ST_IDLE);
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        col_prod = 19'(r_q) * 19'(TEXT_COLS);
        col_rem  = 12'(19'(r_cell) - col_prod);
        col_over = (col_rem >= 12'(TEXT_COLS));
        col_fin  = col_over ? col_rem - 12'(TEXT_COLS) : col_rem;
        y_est    = 9'(int'(r_q) * GLYPH_LINES);
    end

    always_comb begin
        font_byte = r_line[0] ? i_rdata_a[15:8] : i_rdata_a[7:0];
        if (r_cursor && (r_line >= CURSOR_LINE)) begin
            font_byte = ~font_byte;
        end
        next_line = r_line + LINE_W'(1);
    end

    // next state, memory requests and results
    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_valid    = 1'b0;
        n_res      = r_res;
        n_cell     = r_cell;
        n_q        = r_q;
        n_col      = r_col;
        n_row      = r_row;
        n_cursor   = r_cursor;
        n_ch       = r_ch;
        n_fg       = r_fg;
        n_bg       = r_bg;
        n_line     = r_line;
        o_ram_req  = '0;

        case (r_state)
            // zero the window one word a cycle
            ST_CLEAR: begin
                o_ram_req.we    = 1'b1;
                o_ram_req.be    = 2'b11;
                o_ram_req.waddr = r_clr_addr;
                n_clr_addr      = r_clr_addr + WADDR_W'(1);
                if (r_clr_addr == WADDR_W'(WIN_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (i_start && i_func == FUNC_WRITE) begin
                    // store the byte, then classify the offset
                    o_ram_req.we    = 1'b1;
                    o_ram_req.be    = i_window_offset[0] ? 2'b10 : 2'b01;
                    o_ram_req.waddr = WADDR_W'(i_window_offset[12:1]);
                    o_ram_req.wdata = {i_write_byte, i_write_byte};
                    n_cell = i_window_offset[12:1];
                    n_q    = 12'((29'(i_window_offset[12:1]) * 29'(COL_RECIP)) >> 16);
                    if (i_cfg.video_mode == 8'd0) begin
                        if (i_window_offset < PAL_BASE) begin
                            n_state = ST_WR_CELL;
                        end else if (i_window_offset < PAL_END ||
                                     i_window_offset >= FONT_BASE) begin
                            n_valid = 1'b1;
                            n_res   = '0;
                            n_res.redraw_kind = REDRAW_FULL;
                        end
                    end
                end else if (i_start && i_func == FUNC_RENDER) begin
                    // fetch the character and attribute word
                    o_ram_req.raddr_a = WADDR_W'(int'(i_cell_row) * TEXT_COLS +
                                                 int'(i_cell_col));
                    n_col    = i_cell_col;
                    n_row    = i_cell_row;
                    n_cursor = (i_cell_col == i_cfg.cursor_col) &&
                               (i_cell_row == i_cfg.cursor_row) && i_blink_phase;
                    if (i_cfg.video_mode == 8'd0 &&
                        {1'b0, i_cell_col} < 8'(TEXT_COLS) &&
                        {2'b00, i_cell_row} < 7'(TEXT_ROWS)) begin
                        n_state = ST_RD_ATTR;
                    end
                end
            end

            // finish cell / column split and report the touched cell
            ST_WR_CELL: begin
                n_state = ST_IDLE;
                if (14'(r_cell) < 14'(NUM_CELLS)) begin
                    n_valid = 1'b1;
                    n_res   = '0;
                    n_res.redraw_kind = REDRAW_CELL;
                    n_res.screen_x    = 10'({col_fin, 3'b000});
                    n_res.screen_y    = col_over ? y_est + 9'(GLYPH_LINES) : y_est;
                end
            end

            // attribute arrives, fetch both palette entries
            ST_RD_ATTR: begin
                n_ch = i_rdata_a[7:0];
                o_ram_req.raddr_a = PAL_WORD + WADDR_W'(i_rdata_a[11:8]);
                o_ram_req.raddr_b = PAL_WORD + WADDR_W'(i_rdata_a[15:12]);
                n_state = ST_RD_PAL;
            end

            // colors arrive, fetch the first glyph line
            ST_RD_PAL: begin
                n_fg   = pal_rgb(i_rdata_a);
                n_bg   = pal_rgb(i_rdata_b);
                n_line = '0;
                o_ram_req.raddr_a = font_addr(r_ch, '0);
                n_state = ST_GLYPH;
            end

            // one glyph line per cycle
            ST_GLYPH: begin
                o_ram_req.raddr_a = font_addr(r_ch, next_line);
                n_valid = 1'b1;
                for (int x = 0; x < 8; x++) begin
                    n_res.pixels[x] = font_byte[7 - x] ? r_fg : r_bg;
                end
                n_res.screen_x    = 10'({r_col, 3'b000});
                n_res.screen_y    = 9'(int'(r_row) * GLYPH_LINES + int'(r_line));
                n_res.last_row    = (r_line == LAST_LINE);
                n_res.redraw_kind = REDRAW_PIXEL;
                n_line = next_line;
                if (r_line == LAST_LINE) begin
                    n_state = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_valid    <= n_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_res    <= n_res;
        r_cell   <= n_cell;
        r_q      <= n_q;
        r_col    <= n_col;
        r_row    <= n_row;
        r_cursor <= n_cursor;
        r_ch     <= n_ch;
        r_fg     <= n_fg;
        r_bg     <= n_bg;
        r_line   <= n_line;
    end

endmodule

[tb/tmcr_render_checker.sv]
`timescale 1ns / 100ps

module tmcr_render_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        i_func,
    input  logic [12:0] i_window_offset,
    input  logic [7:0]  i_write_byte,
    input  logic [6:0]  i_cell_col,
    input  logic [4:0]  i_cell_row,
    input  logic        i_blink_phase,
    input  logic        i_cfg_valid,
    input  logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        o_result_strobe,
    input  logic [23:0] o_pixel_0,
    input  logic [23:0] o_pixel_1,
    input  logic [23:0] o_pixel_2,
    input  logic [23:0] o_pixel_3,
    input  logic [23:0] o_pixel_4,
    input  logic [23:0] o_pixel_5,
    input  logic [23:0] o_pixel_6,
    input  logic [23:0] o_pixel_7,
    input  logic [9:0]  o_screen_x,
    input  logic [8:0]  o_screen_y,
    input  logic        o_last_row,
    input  logic [1:0]  o_redraw_kind,
    output int          o_fail_count,
    output int          o_lines_pending
);
    import tmcr_pkg::*;

    // shadow copy of the video window and display registers
    logic [7:0]       window_copy [0:8191];
    t_cfg             disp_regs;
    t_result          lines_due [$];
    int               mismatch_count = 0;
    logic [7:0][23:0] seen_px;

    assign seen_px = {o_pixel_7, o_pixel_6, o_pixel_5, o_pixel_4,
                      o_pixel_3, o_pixel_2, o_pixel_1, o_pixel_0};

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
    endtask

    task automatic clear_window();
        int i;
        for (i = 0; i < 8192; i++)
            window_copy[i] = 8'h00;
    endtask

    // palette entry: low byte green/blue nibbles, high byte red nibble
    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [7:0] gb;
        logic [7:0] red;
        gb  = window_copy[PAL_BASE + 2 * idx];
        red = window_copy[PAL_BASE + 2 * idx + 1];
        return {red[3:0], 4'h0, gb[7:4], 4'h0, gb[3:0], 4'h0};
    endfunction

    // store a byte and queue the redraw notice it causes
    task automatic window_write(input logic [12:0] off, input logic [7:0] data);
        t_result note;
        int      cell_idx;
        window_copy[off] = data;
        note = '0;
        if (disp_regs.video_mode == 8'd0) begin
            if (off < PAL_BASE) begin
                cell_idx = int'(off >> 1);
                if (cell_idx < NUM_CELLS) begin
                    note.screen_x    = 10'(8 * (cell_idx % TEXT_COLS));
                    note.screen_y    = 9'(GLYPH_LINES * (cell_idx / TEXT_COLS));
                    note.redraw_kind = REDRAW_CELL;
                    lines_due.push_back(note);
                end
            end else if (off < PAL_END || off >= FONT_BASE) begin
                note.redraw_kind = REDRAW_FULL;
                lines_due.push_back(note);
            end
        end
    endtask

    // expand one cell into its glyph lines
    task automatic render_glyph_lines(input logic [6:0] col, input logic [4:0] row,
                                      input logic blink);
        t_result    line;
        logic [12:0] base;
        logic [7:0] ch;
        logic [7:0] attr;
        logic [7:0] bits;
        logic       cursor_hit;
        int         y;
        int         x;
        if (disp_regs.video_mode != 8'd0 || col >= TEXT_COLS || row >= TEXT_ROWS)
            return;
        base       = 13'(2 * (row * TEXT_COLS + col));
        ch         = window_copy[base];
        attr       = window_copy[base + 1];
        cursor_hit = (col == disp_regs.cursor_col) && (row == disp_regs.cursor_row) && blink;
        for (y = 0; y < GLYPH_LINES; y++) begin
            line = '0;
            bits = window_copy[FONT_BASE + 16 * ch + y];
            // blinking cursor flips the bottom two lines
            if (cursor_hit && y >= GLYPH_LINES - 2)
                bits = ~bits;
            for (x = 0; x < 8; x++)
                line.pixels[x] = palette_rgb(bits[7 - x] ? attr[3:0] : attr[7:4]);
            line.screen_x    = 10'(8 * col);
            line.screen_y    = 9'(GLYPH_LINES * row + y);
            line.last_row    = (y == GLYPH_LINES - 1);
            line.redraw_kind = REDRAW_PIXEL;
            lines_due.push_back(line);
        end
    endtask

    task automatic check_line();
        t_result want;
        int      x;
        if (lines_due.size() == 0) begin
            report_mismatch("result with nothing expected", 24'(o_screen_y), 24'h0);
            return;
        end
        want = lines_due.pop_front();
        for (x = 0; x < 8; x++)
            if (seen_px[x] !== want.pixels[x])
                report_mismatch($sformatf("pixel_%0d", x), seen_px[x], want.pixels[x]);
        if (o_screen_x !== want.screen_x)
            report_mismatch("screen_x", 24'(o_screen_x), 24'(want.screen_x));
        if (o_screen_y !== want.screen_y)
            report_mismatch("screen_y", 24'(o_screen_y), 24'(want.screen_y));
        if (o_last_row !== want.last_row)
            report_mismatch("last_row", 24'(o_last_row), 24'(want.last_row));
        if (o_redraw_kind !== want.redraw_kind)
            report_mismatch("redraw_kind", 24'(o_redraw_kind), 24'(want.redraw_kind));
    endtask

    // results first, then the new item, then register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_window();
            disp_regs = '0;
            lines_due.delete();
        end else begin
            if (o_result_strobe)
                check_line();
            if (start && !busy) begin
                if (i_func == FUNC_WRITE)
                    window_write(i_window_offset, i_write_byte);
                else
                    render_glyph_lines(i_cell_col, i_cell_row, i_blink_phase);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_VIDEO_MODE: disp_regs.video_mode = i_cfg_data;
                    CFG_CURSOR_COL: disp_regs.cursor_col = i_cfg_data[6:0];
                    CFG_CURSOR_ROW: disp_regs.cursor_row = i_cfg_data[4:0];
                    default: ;
                endcase
            end
        end
        o_fail_count    <= mismatch_count;
        o_lines_pending <= lines_due.size();
    end

endmodule

[tb/tb_text_mode_cell_renderer_unit.sv]
`timescale 1ns / 100ps

module tb_text_mode_cell_renderer_unit;
    import tmcr_pkg::*;

    // index with no register behind it
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_func;
    logic [12:0] i_window_offset;
    logic [7:0]  i_write_byte;
    logic [6:0]  i_cell_col;
    logic [4:0]  i_cell_row;
    logic        i_blink_phase;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_result_strobe;
    logic [23:0] o_pixel_0;
    logic [23:0] o_pixel_1;
    logic [23:0] o_pixel_2;
    logic [23:0] o_pixel_3;
    logic [23:0] o_pixel_4;
    logic [23:0] o_pixel_5;
    logic [23:0] o_pixel_6;
    logic [23:0] o_pixel_7;
    logic [9:0]  o_screen_x;
    logic [8:0]  o_screen_y;
    logic        o_last_row;
    logic [1:0]  o_redraw_kind;

    int          fail_count;
    int          lines_pending;
    logic [6:0]  cur_col;
    logic [4:0]  cur_row;
    bit          gaps_on;

    text_mode_cell_renderer_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_window_offset (i_window_offset),
        .i_write_byte    (i_write_byte),
        .i_cell_col      (i_cell_col),
        .i_cell_row      (i_cell_row),
        .i_blink_phase   (i_blink_phase),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_pixel_0       (o_pixel_0),
        .o_pixel_1       (o_pixel_1),
        .o_pixel_2       (o_pixel_2),
        .o_pixel_3       (o_pixel_3),
        .o_pixel_4       (o_pixel_4),
        .o_pixel_5       (o_pixel_5),
        .o_pixel_6       (o_pixel_6),
        .o_pixel_7       (o_pixel_7),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .o_last_row      (o_last_row),
        .o_redraw_kind   (o_redraw_kind)
    );

    tmcr_render_checker chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_window_offset (i_window_offset),
        .i_write_byte    (i_write_byte),
        .i_cell_col      (i_cell_col),
        .i_cell_row      (i_cell_row),
        .i_blink_phase   (i_blink_phase),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_pixel_0       (o_pixel_0),
        .o_pixel_1       (o_pixel_1),
        .o_pixel_2       (o_pixel_2),
        .o_pixel_3       (o_pixel_3),
        .o_pixel_4       (o_pixel_4),
        .o_pixel_5       (o_pixel_5),
        .o_pixel_6       (o_pixel_6),
        .o_pixel_7       (o_pixel_7),
        .o_screen_x      (o_screen_x),
        .o_screen_y      (o_screen_y),
        .o_last_row      (o_last_row),
        .o_redraw_kind   (o_redraw_kind),
        .o_fail_count    (fail_count),
        .o_lines_pending (lines_pending)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // one item: hold start until the block takes it
    task automatic send_item(input logic func, input logic [12:0] off,
                             input logic [7:0] data, input logic [6:0] col,
                             input logic [4:0] row, input logic blink);
        int gap;
        @(negedge i_clk);
        start           <= 1'b1;
        i_func          <= func;
        i_window_offset <= off;
        i_write_byte    <= data;
        i_cell_col      <= col;
        i_cell_row      <= row;
        i_blink_phase   <= blink;
        while (busy)
            @(negedge i_clk);
        @(posedge i_clk);
        gap = gaps_on ? sender_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // unused fields carry random junk
    task automatic put_write(input logic [12:0] off, input logic [7:0] data);
        send_item(FUNC_WRITE, off, data, 7'($urandom), 5'($urandom), 1'($urandom));
    endtask

    task automatic put_render(input logic [6:0] col, input logic [4:0] row,
                              input logic blink);
        send_item(FUNC_RENDER, 13'($urandom), 8'($urandom), col, row, blink);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        while (!o_cfg_ready)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // drain results, let a silent render finish, then wait for idle
    task automatic wait_idle();
        @(negedge i_clk);
        start <= 1'b0;
        while (lines_pending != 0)
            @(negedge i_clk);
        repeat (24) @(negedge i_clk);
        while (busy)
            @(negedge i_clk);
    endtask

    task automatic program_display(input logic [7:0] mode, input logic [7:0] col_data,
                                   input logic [7:0] row_data, input bit spare);
        wait_idle();
        write_reg(CFG_VIDEO_MODE, mode);
        write_reg(CFG_CURSOR_COL, col_data);
        write_reg(CFG_CURSOR_ROW, row_data);
        if (spare)
            write_reg(CFG_SPARE, 8'hFF);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        cur_col = col_data[6:0];
        cur_row = row_data[4:0];
    endtask

    // small glyph set so font writes and renders meet
    function automatic logic [7:0] hot_glyph();
        int g;
        g = $urandom_range(0, 7);
        return (g < 4) ? 8'(g) : 8'(248 + g);
    endfunction

    // cursor cell half the time, else a small corner of the screen
    task automatic pick_cell(output logic [6:0] col, output logic [4:0] row);
        if ($urandom_range(0, 1) && cur_col < TEXT_COLS && cur_row < TEXT_ROWS) begin
            col = cur_col;
            row = cur_row;
        end else begin
            col = $urandom_range(0, 7);
            row = $urandom_range(0, 3);
        end
    endtask

    task automatic random_item();
        int          r;
        logic [6:0]  col;
        logic [4:0]  row;
        logic [12:0] off;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            pick_cell(col, row);
            put_render(col, row, 1'($urandom_range(0, 1)));
        end else if (r < 40) begin
            put_render(7'($urandom), 5'($urandom), 1'($urandom));
        end else if (r < 60) begin
            pick_cell(col, row);
            off = 13'(2 * (row * TEXT_COLS + col)) + 13'($urandom_range(0, 1));
            if (!off[0])
                put_write(off, hot_glyph());
            else
                put_write(off, 8'($urandom));
        end else if (r < 75) begin
            put_write(FONT_BASE + 13'(16 * hot_glyph() + $urandom_range(0, 15)),
                      8'($urandom));
        end else if (r < 85) begin
            put_write(PAL_BASE + 13'($urandom_range(0, 31)), 8'($urandom));
        end else begin
            put_write(13'($urandom), 8'($urandom));
        end
    endtask

    // run limit
    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // stimulus and verdict
    initial begin
        int ph;
        int n;
        int count;
        int guard;
        i_rst_n         = 1'b0;
        start           = 1'b0;
        i_func          = FUNC_WRITE;
        i_window_offset = '0;
        i_write_byte    = '0;
        i_cell_col      = '0;
        i_cell_row      = '0;
        i_blink_phase   = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_VIDEO_MODE;
        i_cfg_data      = '0;
        cur_col         = '0;
        cur_row         = '0;
        gaps_on         = 1'b1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: palette, font and text extremes, then renders
        program_display(8'd0, 8'd2, 8'd0, 1'b0);
        put_write(PAL_BASE, 8'h5A);
        put_write(PAL_BASE + 13'd1, 8'hF3);
        put_write(PAL_END - 13'd2, 8'hFF);
        put_write(PAL_END - 13'd1, 8'hFF);
        put_write(FONT_BASE + 13'h410, 8'h81);
        put_write(FONT_BASE + 13'h41F, 8'h3C);
        put_write(13'h1FFF, 8'hA5);
        put_write(13'h0000, 8'h41);
        put_write(13'h0001, 8'h0F);
        put_write(13'h0002, 8'h00);
        put_write(13'h0004, 8'h41);
        put_write(13'h0005, 8'hF0);
        put_write(PAL_BASE - 13'd2, 8'hFF);
        put_write(PAL_BASE - 13'd1, 8'h5F);
        // gap between palette and font stores without a redraw
        put_write(PAL_END, 8'h12);
        put_write(FONT_BASE - 13'd1, 8'h34);
        put_render(7'd0, 5'd0, 1'b1);
        put_render(7'd2, 5'd0, 1'b1);
        put_render(7'd2, 5'd0, 1'b0);
        put_render(7'd79, 5'd24, 1'b1);
        put_render(7'd5, 5'd5, 1'b0);
        // cells outside the grid
        put_render(7'd80, 5'd0, 1'b1);
        put_render(7'd0, 5'd25, 1'b0);
        put_render(7'd127, 5'd31, 1'b1);

        // random phases over several display settings
        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                0: begin
                    program_display(8'd0, 8'd79, 8'd24, 1'b1);
                    count = 90; gaps_on = 1'b1;
                end
                1: begin
                    program_display(8'd0, 8'd0, 8'd0, 1'b0);
                    count = 60; gaps_on = 1'b0;
                end
                2: begin
                    program_display(8'd255, 8'($urandom), 8'($urandom), 1'b0);
                    count = 25; gaps_on = 1'b1;
                end
                3: begin
                    // cursor parked off the grid, masked high bits
                    program_display(8'd0, 8'hFF, 8'hFF, 1'b0);
                    count = 50; gaps_on = 1'b1;
                end
                4: begin
                    program_display(8'd0, 8'($urandom_range(0, 79)),
                                    8'($urandom_range(0, 24)), 1'b0);
                    count = 90; gaps_on = 1'b1;
                end
                5: begin
                    program_display(8'($urandom_range(1, 254)), 8'($urandom),
                                    8'($urandom), 1'b0);
                    count = 20; gaps_on = 1'b0;
                end
                default: begin
                    program_display(8'd0, 8'($urandom_range(0, 79)),
                                    8'($urandom_range(0, 24)), 1'b0);
                    count = 95; gaps_on = 1'b1;
                end
            endcase
            for (n = 0; n < count; n++)
                random_item();
        end

        // drain and settle
        @(negedge i_clk);
        start <= 1'b0;
        guard = 0;
        while (lines_pending != 0 && guard < 5000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (30) @(negedge i_clk);
        if (fail_count == 0 && lines_pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
